### design/i2cm_pkg.sv
// Package: shared types, codes and reset constants of the I2C register master.
package i2cm_pkg;

  localparam int unsigned HP_W   = 16;
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned CIDX_W = 2;

  localparam logic [HP_W-1:0]   HALF_PERIOD_RST = 16'd255;
  localparam logic [ADDR_W-1:0] DEV_ADDR_RST    = 7'd17;

  localparam logic [CIDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DEV_ADDR    = 2'd1;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_A  = 4'd1,
    PH_ST_B  = 4'd2,
    PH_TX_LO = 4'd3,
    PH_TX_HI = 4'd4,
    PH_AI_LO = 4'd5,
    PH_AI_HI = 4'd6,
    PH_RX_LO = 4'd7,
    PH_RX_HI = 4'd8,
    PH_AO_LO = 4'd9,
    PH_AO_HI = 4'd10,
    PH_RS_LO = 4'd11,
    PH_SP_LO = 4'd12,
    PH_SP_A  = 4'd13,
    PH_SP_B  = 4'd14
  } phase_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [7:0]        reg_addr;
    logic [DATA_W-1:0] write_data;
    logic              sda_in;
  } in_word_t;

  typedef struct packed {
    logic              scl;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
    logic              nack_seen;
  } out_word_t;

  typedef struct packed {
    logic [CIDX_W-1:0] reg_index;
    logic [HP_W-1:0]   wdata;
  } cfg_word_t;

  typedef struct packed {
    logic [HP_W-1:0]   half_period_ticks;
    logic [ADDR_W-1:0] device_address;
  } cfg_regs_t;

endpackage

### design/i2cm_if.sv
// Interfaces: valid/ready channels for input, result and configuration words.
interface i2cm_in_if import i2cm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if import i2cm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if import i2cm_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/i2cm_cfg_regs.sv
// Configuration registers: half period and device address.
module i2cm_cfg_regs import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  cfg_word_t wr_word,
  output cfg_regs_t regs
);

  logic [HP_W-1:0]   half_period_r;
  logic [ADDR_W-1:0] dev_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      dev_addr_r    <= DEV_ADDR_RST;
    end else if (wr_en) begin
      if (wr_word.reg_index == CFG_HALF_PERIOD) begin
        half_period_r <= wr_word.wdata;
      end
      if (wr_word.reg_index == CFG_DEV_ADDR) begin
        dev_addr_r <= wr_word.wdata[ADDR_W-1:0];
      end
    end
  end

  assign regs.half_period_ticks = half_period_r;
  assign regs.device_address    = dev_addr_r;

endmodule

### design/i2cm_seq.sv
// Bus sequencer: phase timing, byte shifting and line levels, one step per word.
module i2cm_seq import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  in_word,
  input  cfg_regs_t cfg,
  output out_word_t res
);

  phase_t            phase_r, phase_nxt;
  logic [HP_W-1:0]   tick_r, tick_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [2:0]        byte_r, byte_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              is_read_r, is_read_nxt;
  logic [7:0]        reg_addr_r, reg_addr_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic              nack_r, nack_nxt;
  logic              done;
  logic [HP_W-1:0]   hp_m1;
  logic [2:0]        byte_inc;

  function automatic logic [7:0] tx_byte(input logic [2:0] idx, input logic rd,
                                         input logic [ADDR_W-1:0] dev,
                                         input logic [7:0] ra,
                                         input logic [DATA_W-1:0] wd);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      3'd0:    b = {dev, 1'b0};
      3'd1:    b = ra;
      3'd2:    b = rd ? {dev, 1'b1} : wd[15:8];
      3'd3:    b = wd[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign hp_m1    = (cfg.half_period_ticks == '0) ? '0 : cfg.half_period_ticks - 16'd1;
  assign byte_inc = byte_r + 3'd1;

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    byte_nxt     = byte_r;
    shift_nxt    = shift_r;
    is_read_nxt  = is_read_r;
    reg_addr_nxt = reg_addr_r;
    wdata_nxt    = wdata_r;
    rdata_nxt    = rdata_r;
    nack_nxt     = nack_r;
    done         = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (in_word.func == FUNC_WRITE || in_word.func == FUNC_READ) begin
        is_read_nxt  = (in_word.func == FUNC_READ);
        reg_addr_nxt = in_word.reg_addr;
        wdata_nxt    = in_word.write_data;
        byte_nxt     = 3'd0;
        bit_nxt      = 3'd0;
        shift_nxt    = 8'h00;
        nack_nxt     = 1'b0;
        if (in_word.func == FUNC_READ) begin
          rdata_nxt = '0;
        end
        tick_nxt  = '0;
        phase_nxt = PH_ST_A;
      end
    end else if (tick_r < hp_m1) begin
      tick_nxt = tick_r + 16'd1;
    end else begin
      tick_nxt = '0;
      unique case (phase_r)
        PH_ST_A: phase_nxt = PH_ST_B;
        PH_ST_B: begin
          shift_nxt = tx_byte(byte_r, is_read_r, cfg.device_address, reg_addr_r, wdata_r);
          bit_nxt   = 3'd0;
          phase_nxt = PH_TX_LO;
        end
        PH_TX_LO: phase_nxt = PH_TX_HI;
        PH_TX_HI: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_r + 3'd1;
          phase_nxt = (bit_r == 3'd7) ? PH_AI_LO : PH_TX_LO;
        end
        PH_AI_LO: phase_nxt = PH_AI_HI;
        PH_AI_HI: begin
          if (in_word.sda_in) begin
            nack_nxt = 1'b1;
          end
          byte_nxt = byte_inc;
          if (is_read_r && byte_inc == 3'd2) begin
            phase_nxt = PH_RS_LO;
          end else if (is_read_r && byte_inc >= 3'd3) begin
            bit_nxt   = 3'd0;
            phase_nxt = PH_RX_LO;
          end else if (!is_read_r && byte_inc >= 3'd4) begin
            phase_nxt = PH_SP_LO;
          end else begin
            shift_nxt = tx_byte(byte_inc, is_read_r, cfg.device_address, reg_addr_r, wdata_r);
            bit_nxt   = 3'd0;
            phase_nxt = PH_TX_LO;
          end
        end
        PH_RS_LO: phase_nxt = PH_ST_A;
        PH_RX_LO: phase_nxt = PH_RX_HI;
        PH_RX_HI: begin
          rdata_nxt = {rdata_r[DATA_W-2:0], in_word.sda_in};
          bit_nxt   = bit_r + 3'd1;
          phase_nxt = (bit_r == 3'd7) ? PH_AO_LO : PH_RX_LO;
        end
        PH_AO_LO: phase_nxt = PH_AO_HI;
        PH_AO_HI: begin
          byte_nxt = byte_inc;
          if (byte_inc == 3'd4) begin
            bit_nxt   = 3'd0;
            phase_nxt = PH_RX_LO;
          end else begin
            phase_nxt = PH_SP_LO;
          end
        end
        PH_SP_LO: phase_nxt = PH_SP_A;
        PH_SP_A:  phase_nxt = PH_SP_B;
        PH_SP_B: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // line levels follow the phase entered on this step
  always_comb begin
    res.scl     = 1'b1;
    res.sda_out = 1'b1;
    unique case (phase_nxt)
      PH_ST_B:  begin res.scl = 1'b1; res.sda_out = 1'b0;                end
      PH_TX_LO: begin res.scl = 1'b0; res.sda_out = shift_nxt[7];        end
      PH_TX_HI: begin res.scl = 1'b1; res.sda_out = shift_nxt[7];        end
      PH_AI_LO: begin res.scl = 1'b0; res.sda_out = 1'b1;                end
      PH_RX_LO: begin res.scl = 1'b0; res.sda_out = 1'b1;                end
      PH_AO_LO: begin res.scl = 1'b0; res.sda_out = (byte_nxt != 3'd3); end
      PH_AO_HI: begin res.scl = 1'b1; res.sda_out = (byte_nxt != 3'd3); end
      PH_RS_LO: begin res.scl = 1'b0; res.sda_out = 1'b1;                end
      PH_SP_LO: begin res.scl = 1'b0; res.sda_out = 1'b0;                end
      PH_SP_A:  begin res.scl = 1'b1; res.sda_out = 1'b0;                end
      default:  begin res.scl = 1'b1; res.sda_out = 1'b1;                end
    endcase
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.read_data = rdata_nxt;
    res.nack_seen = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_r     <= '0;
      byte_r    <= '0;
      is_read_r <= 1'b0;
      rdata_r   <= '0;
      nack_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      byte_r    <= byte_nxt;
      is_read_r <= is_read_nxt;
      rdata_r   <= rdata_nxt;
      nack_r    <= nack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift_r    <= shift_nxt;
      reg_addr_r <= reg_addr_nxt;
      wdata_r    <= wdata_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == PH_IDLE)
    else $error("sequencer not idle after stop");

  a_scl_low_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && !res.scl |-> res.busy_res)
    else $error("SCL driven low while not busy");

  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_r <= 3'd5)
    else $error("byte index out of range");
`endif

endmodule

### design/i2c_master_reg16_access.sv
// Top level: I2C master for 16-bit register reads and writes, one word per time-base tick.
//
// Usage:
//   in_ch  : one word per time-base tick: func (0 tick, 1 write, 2 read),
//            reg_addr, write_data and the sampled SDA level. Commands are
//            ignored while an access is in progress.
//   out_ch : exactly one word per input word, in order: SCL and SDA levels,
//            busy, done (on the tick the stop completes), read_data and the
//            sticky nack flag of the current or last access.
//   cfg_ch : index 0 half period in ticks, index 1 seven-bit device address;
//            other indexes are ignored. Write only while idle. Always ready.
// Timing: an input register and a result register with the sequencer step
//   between them; one word per cycle sustained while out_ch is ready.
// Stall: while out_ch is held off the result register keeps its word and
//   the input register takes one more word, then in_ch.ready drops.
// Reset (rst_n low, synchronous): bus idle with both lines released, half
//   period 255, device address 17, both pipeline registers empty.
module i2c_master_reg16_access import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);

  logic      in_vld_r;
  in_word_t  in_data_r;
  logic      out_vld_r;
  out_word_t out_data_r;
  logic      out_load;
  out_word_t step_res;
  cfg_regs_t cfg_regs;

  assign out_load     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || out_load;
  assign cfg_ch.ready = 1'b1;

  i2cm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_word (cfg_ch.data),
    .regs    (cfg_regs)
  );

  i2cm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (out_load),
    .in_word (in_data_r),
    .cfg     (cfg_regs),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= step_res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_vld_r)
    else $error("result word lost after step");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> in_vld_r)
    else $error("accepted word not held in input register");

  a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_load |=> in_vld_r && $stable(in_data_r))
    else $error("waiting input word dropped or changed");
`endif

endmodule

### sim/tb_top.sv
// Testbench for the I2C register master: directed table, random accesses, all results checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int PIPE_LAT    = 2;
  localparam int RAND_WORDS  = 1200;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 200;
  localparam int RUN_OUT     = -1;

  localparam int GAP_NONE  = 0;
  localparam int GAP_LIGHT = 1;
  localparam int GAP_FULL  = 2;

  localparam int SDA_NOISE = 0;
  localparam int SDA_ACK   = 1;
  localparam int SDA_NACK  = 2;

  localparam logic [1:0]        FUNC_SPARE  = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam out_word_t IDLE_OUT  = '{1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0};
  localparam out_word_t START_OUT = '{1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0};
  localparam in_word_t  NO_WORD   = '0;
  localparam cfg_word_t NO_CFG    = '0;

  typedef struct {
    bit         is_cfg;
    cfg_word_t  cfg;
    in_word_t   word;
    int         tail;
    logic [1:0] tail_func;
    bit         has_exp;
    out_word_t  exp_word;
  } stim_row_t;

  // tail: ticks sent after the word, RUN_OUT = until the access has ended
  stim_row_t dir_rows [17] = '{
    '{0, NO_CFG, '{FUNC_TICK, 8'h00, 16'h0000, 1'b1}, 0, FUNC_TICK, 1, IDLE_OUT},
    '{0, NO_CFG, '{FUNC_SPARE, 8'hff, 16'hffff, 1'b0}, 0, FUNC_TICK, 1, IDLE_OUT},
    '{0, NO_CFG, '{FUNC_TICK, 8'h00, 16'h0000, 1'b0}, 0, FUNC_TICK, 1, IDLE_OUT},
    '{1, '{CFG_SPARE_2, 16'hffff}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{1, '{CFG_SPARE_3, 16'h0001}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{1, '{CFG_HALF_PERIOD, 16'h0000}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{1, '{CFG_DEV_ADDR, 16'hff7f}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{0, NO_CFG, '{FUNC_WRITE, 8'hff, 16'hffff, 1'b0}, RUN_OUT, FUNC_READ, 1, START_OUT},
    '{0, NO_CFG, '{FUNC_READ, 8'h00, 16'h0000, 1'b1}, RUN_OUT, FUNC_SPARE, 1, START_OUT},
    '{1, '{CFG_DEV_ADDR, 16'h0000}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{1, '{CFG_HALF_PERIOD, 16'h0001}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{0, NO_CFG, '{FUNC_READ, 8'h5a, 16'ha5a5, 1'b0}, RUN_OUT, FUNC_WRITE, 1, START_OUT},
    '{0, NO_CFG, '{FUNC_WRITE, 8'h00, 16'h0000, 1'b1}, RUN_OUT, FUNC_READ, 1, START_OUT},
    '{1, '{CFG_HALF_PERIOD, 16'hffff}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{0, NO_CFG, '{FUNC_WRITE, 8'h3c, 16'hc33c, 1'b0}, 40, FUNC_TICK, 1, START_OUT},
    '{1, '{CFG_HALF_PERIOD, 16'h0002}, NO_WORD, 0, FUNC_TICK, 0, IDLE_OUT},
    '{0, NO_CFG, '{FUNC_TICK, 8'h00, 16'h0000, 1'b0}, RUN_OUT, FUNC_TICK, 0, IDLE_OUT}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_master_reg16_access dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // bus sequencer model
  logic [HP_W-1:0]   m_hp      = HALF_PERIOD_RST;
  logic [ADDR_W-1:0] m_dev     = DEV_ADDR_RST;
  phase_t            m_phase   = PH_IDLE;
  logic [15:0]       m_ticks   = '0;
  logic [3:0]        m_bit     = '0;
  logic [2:0]        m_byte    = '0;
  logic [7:0]        m_shift   = '0;
  logic              m_is_read = 1'b0;
  logic [7:0]        m_reg     = '0;
  logic [15:0]       m_data    = '0;
  logic [15:0]       m_rd      = '0;
  logic              m_nack    = 1'b0;
  logic              scl_lvl   = 1'b1;
  logic              sda_lvl   = 1'b1;

  out_word_t   exp_bus_q [$];
  int unsigned words_sent = 0;
  int unsigned rx_words   = 0;
  int unsigned mismatches = 0;
  int          tx_mode    = GAP_NONE;

  function automatic logic [7:0] tx_byte_for(input logic [2:0] idx);
    logic [7:0] dev_byte;
    dev_byte = {m_dev, 1'b0};
    case (idx)
      3'd0: return dev_byte;
      3'd1: return m_reg;
      3'd2: return m_is_read ? (dev_byte | 8'h01) : m_data[15:8];
      3'd3: return m_data[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic void load_byte();
    m_shift = tx_byte_for(m_byte);
    m_bit   = '0;
    m_phase = PH_TX_LO;
  endfunction

  function automatic void drive_levels();
    logic txb;
    logic ackb;
    txb  = m_shift[7];
    ackb = (m_byte != 3'd3);
    case (m_phase)
      PH_ST_B:  begin scl_lvl = 1'b1; sda_lvl = 1'b0; end
      PH_TX_LO: begin scl_lvl = 1'b0; sda_lvl = txb; end
      PH_TX_HI: begin scl_lvl = 1'b1; sda_lvl = txb; end
      PH_AI_LO: begin scl_lvl = 1'b0; sda_lvl = 1'b1; end
      PH_RX_LO: begin scl_lvl = 1'b0; sda_lvl = 1'b1; end
      PH_AO_LO: begin scl_lvl = 1'b0; sda_lvl = ackb; end
      PH_AO_HI: begin scl_lvl = 1'b1; sda_lvl = ackb; end
      PH_RS_LO: begin scl_lvl = 1'b0; sda_lvl = 1'b1; end
      PH_SP_LO: begin scl_lvl = 1'b0; sda_lvl = 1'b0; end
      PH_SP_A:  begin scl_lvl = 1'b1; sda_lvl = 1'b0; end
      default:  begin scl_lvl = 1'b1; sda_lvl = 1'b1; end
    endcase
  endfunction

  // returns 1 when the stop condition completes
  function automatic logic end_phase(input logic sda);
    case (m_phase)
      PH_ST_A:  m_phase = PH_ST_B;
      PH_ST_B:  load_byte();
      PH_TX_LO: m_phase = PH_TX_HI;
      PH_TX_HI: begin
        m_shift = m_shift << 1;
        m_bit++;
        if (m_bit >= 4'd8) begin
          m_bit   = '0;
          m_phase = PH_AI_LO;
        end else begin
          m_phase = PH_TX_LO;
        end
      end
      PH_AI_LO: m_phase = PH_AI_HI;
      PH_AI_HI: begin
        if (sda) m_nack = 1'b1;
        m_byte++;
        if (m_is_read) begin
          if (m_byte == 3'd2) begin
            m_phase = PH_RS_LO;
          end else if (m_byte >= 3'd3) begin
            m_bit   = '0;
            m_phase = PH_RX_LO;
          end else begin
            load_byte();
          end
        end else if (m_byte >= 3'd4) begin
          m_phase = PH_SP_LO;
        end else begin
          load_byte();
        end
      end
      PH_RS_LO: m_phase = PH_ST_A;
      PH_RX_LO: m_phase = PH_RX_HI;
      PH_RX_HI: begin
        m_rd = {m_rd[14:0], sda};
        m_bit++;
        if (m_bit >= 4'd8) begin
          m_bit   = '0;
          m_phase = PH_AO_LO;
        end else begin
          m_phase = PH_RX_LO;
        end
      end
      PH_AO_LO: m_phase = PH_AO_HI;
      PH_AO_HI: begin
        m_byte++;
        if (m_byte == 3'd4) begin
          m_bit   = '0;
          m_phase = PH_RX_LO;
        end else begin
          m_phase = PH_SP_LO;
        end
      end
      PH_SP_LO: m_phase = PH_SP_A;
      PH_SP_A:  m_phase = PH_SP_B;
      PH_SP_B: begin
        m_phase = PH_IDLE;
        return 1'b1;
      end
      default: m_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic out_word_t bus_tick(input in_word_t w);
    out_word_t   r;
    logic        done;
    int unsigned h;
    done = 1'b0;
    if (m_phase == PH_IDLE) begin
      if (w.func == FUNC_WRITE || w.func == FUNC_READ) begin
        m_is_read = (w.func == FUNC_READ);
        m_reg     = w.reg_addr;
        m_data    = w.write_data;
        m_byte    = '0;
        m_bit     = '0;
        m_shift   = '0;
        m_nack    = 1'b0;
        if (m_is_read) m_rd = '0;
        m_ticks   = '0;
        m_phase   = PH_ST_A;
      end
    end else begin
      h = (m_hp == '0) ? 1 : m_hp;
      if (m_ticks + 32'd1 < h) begin
        m_ticks++;
      end else begin
        m_ticks = '0;
        done    = end_phase(w.sda_in);
      end
    end
    drive_levels();
    r.scl       = scl_lvl;
    r.sda_out   = sda_lvl;
    r.busy_res  = (m_phase != PH_IDLE);
    r.done_res  = done;
    r.read_data = m_rd;
    r.nack_seen = m_nack;
    return r;
  endfunction

  function automatic int pick_gap(input int mode);
    case (mode)
      GAP_NONE:  return 0;
      GAP_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      default:   return $urandom_range(0, 13);
    endcase
  endfunction

  function automatic logic [HP_W-1:0] pick_half_period();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return HP_W'($urandom_range(4, 6));
      default: return HP_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic in_word_t rand_word(input logic [1:0] func, input int sda_mode);
    in_word_t w;
    w.func       = func;
    w.reg_addr   = 8'($urandom_range(0, 255));
    w.write_data = 16'($urandom_range(0, 65535));
    case (sda_mode)
      SDA_ACK:  w.sda_in = 1'b0;
      SDA_NACK: w.sda_in = 1'b1;
      default:  w.sda_in = 1'($urandom_range(0, 1));
    endcase
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_exp);
    int        gap;
    out_word_t pred;
    if (words_sent % 64 == 0) tx_mode = $urandom_range(GAP_NONE, GAP_FULL);
    gap = pick_gap(tx_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = bus_tick(w);
    exp_bus_q.push_back(typed ? typed_exp : pred);
    words_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (exp_bus_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CIDX_W-1:0] idx, input logic [HP_W-1:0] val);
    wait_all_results();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_index: idx, wdata: val};
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_HALF_PERIOD) m_hp = val;
    else if (idx == CFG_DEV_ADDR) m_dev = val[ADDR_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (exp_bus_q.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: result word with nothing expected: expected none, got %h", $time, got);
      mismatches++;
    end else begin
      want = exp_bus_q.pop_front();
      cmp_field("scl", 16'(want.scl), 16'(got.scl));
      cmp_field("sda_out", 16'(want.sda_out), 16'(got.sda_out));
      cmp_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
      cmp_field("done_res", 16'(want.done_res), 16'(got.done_res));
      cmp_field("read_data", want.read_data, got.read_data);
      cmp_field("nack_seen", 16'(want.nack_seen), 16'(got.nack_seen));
    end
  endtask

  initial begin : result_side
    int gap;
    int mode;
    mode = GAP_NONE;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_words % 64 == 0) mode = $urandom_range(GAP_NONE, GAP_FULL);
      // one long hold-off so the input side backs up
      gap = (rx_words == HOLD_AT) ? HOLD_CYCLES : pick_gap(mode);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      check_result(out_ch.data);
      rx_words++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d words pending", $time, cycles,
             exp_bus_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_word_t    tick;
    int          sda_mode;
    int unsigned rand_base;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_cfg(dir_rows[i].cfg.reg_index, dir_rows[i].cfg.wdata);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].has_exp, dir_rows[i].exp_word);
        tick      = dir_rows[i].word;
        tick.func = dir_rows[i].tail_func;
        if (dir_rows[i].tail == RUN_OUT) begin
          while (m_phase != PH_IDLE) send_word(tick, 1'b0, IDLE_OUT);
        end else begin
          repeat (dir_rows[i].tail) send_word(tick, 1'b0, IDLE_OUT);
        end
      end
    end

    rand_base = words_sent;
    while (words_sent - rand_base < RAND_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        write_cfg(CFG_HALF_PERIOD, pick_half_period());
        write_cfg(CFG_DEV_ADDR, HP_W'($urandom_range(0, 65535)));
      end else if ($urandom_range(0, 4) == 0) begin
        wait_all_results();
      end
      repeat ($urandom_range(0, 4))
        send_word(rand_word($urandom_range(0, 1) ? FUNC_SPARE : FUNC_TICK, SDA_NOISE),
                  1'b0, IDLE_OUT);
      send_word(rand_word($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE, SDA_NOISE),
                1'b0, IDLE_OUT);
      sda_mode = $urandom_range(SDA_NOISE, SDA_NACK);
      while (m_phase != PH_IDLE)
        send_word(rand_word(2'($urandom_range(0, 3)), sda_mode), 1'b0, IDLE_OUT);
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### i2c_master_reg16_access.f
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_cfg_regs.sv
design/i2cm_seq.sv
design/i2c_master_reg16_access.sv
sim/tb_top.sv
